// ===== hw/rtl/rpa_pkg.sv =====
// Shared definitions for the reference-counted page allocator.
// Operation and status codes, field widths, default page count, control state type.
// No dependencies.
`default_nettype none

package rpa_pkg;

    // Field widths
    localparam int PAGE_W  = 15;
    localparam int COUNT_W = 8;
    localparam int AMT_W   = 8;
    localparam int OP_W    = 2;
    localparam int ST_W    = 2;

    // Default number of physical pages
    localparam int unsigned NUM_PAGES_DEF = 32768;

    // Largest page number the page field can address, plus one
    localparam int unsigned PAGE_SPAN = 32768;

    // Operation codes
    localparam logic [OP_W-1:0] OP_ALLOC  = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE   = 2'd1;
    localparam logic [OP_W-1:0] OP_ADJUST = 2'd2;
    localparam logic [OP_W-1:0] OP_NOP    = 2'd3;

    // Status codes
    localparam logic [ST_W-1:0] STAT_OK    = 2'd0;
    localparam logic [ST_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [ST_W-1:0] STAT_RANGE = 2'd2;

    // Saturation limit of a reference count
    localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;

    // Control sequencer states
    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } t_state;

endpackage

`default_nettype wire

// ===== hw/rtl/rpa_ram.sv =====
// Single-port-write, single-port-read synchronous RAM with registered read data.
// Used for the free page stack and the reference count store.
// No dependencies.
`default_nettype none

module rpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32768,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== hw/rtl/refcounted_page_allocator.sv =====
// Top level of the reference-counted page allocator: sequencer, update logic, result register.
// Depends on rpa_pkg and rpa_ram (free page stack and reference count store).
//
//   channel  | direction | signals
//   ---------+-----------+---------------------------------------------------
//   request  | in        | i_in_valid / o_in_ready, i_operation, i_page, i_amount
//   result   | out       | o_out_valid / i_out_ready, o_status, o_page_out,
//            |           |   o_count_after, o_released
//   config   | in        | i_cfg_we, i_cfg_wdata (first usable page)
//
// A request is accepted in S_IDLE on an edge that reads the count and stack memories; in
// S_EXEC, once the result register is free, they are written back and the result loaded.
// After reset a clearing pass zeroes every entry of the count store, one entry per cycle,
// with o_in_ready low throughout.
// A result waiting in the output register does not block the next accept; the
// write-back cycle holds only while the result register is still occupied.
`default_nettype none

module refcounted_page_allocator #(
    parameter int unsigned NUM_PAGES = rpa_pkg::NUM_PAGES_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic [rpa_pkg::OP_W-1:0]       i_operation,
    input  wire logic [rpa_pkg::PAGE_W-1:0]     i_page,
    input  wire logic signed [rpa_pkg::AMT_W-1:0] i_amount,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic      [rpa_pkg::ST_W-1:0]       o_status,
    output logic      [rpa_pkg::PAGE_W-1:0]     o_page_out,
    output logic      [rpa_pkg::COUNT_W-1:0]    o_count_after,
    output logic                                o_released,
    input  wire logic                           i_cfg_we,
    input  wire logic [rpa_pkg::PAGE_W-1:0]     i_cfg_wdata
);

    import rpa_pkg::*;

    // Count store covers only pages the page field can name
    localparam int unsigned CNT_DEPTH = (NUM_PAGES < PAGE_SPAN) ? NUM_PAGES : PAGE_SPAN;
    localparam int CAW = $clog2(CNT_DEPTH);
    localparam int SAW = $clog2(NUM_PAGES);
    localparam int DW  = $clog2(NUM_PAGES + 1);

    t_state r_state, n_state;

    logic [PAGE_W-1:0]       r_first;
    logic [CAW-1:0]          r_clr_addr;
    logic [DW-1:0]           r_depth, n_depth;
    logic [OP_W-1:0]         r_op;
    logic [PAGE_W-1:0]       r_page;
    logic signed [AMT_W-1:0] r_amt;

    logic                    r_out_valid;
    logic [ST_W-1:0]         r_status, n_status;
    logic [PAGE_W-1:0]       r_page_out, n_page_out;
    logic [COUNT_W-1:0]      r_count, n_count;
    logic                    r_released, n_released;

    logic                    accept;
    logic                    exec_go;
    logic                    clear_done;

    // Memory ports
    logic                    cnt_we, cnt_ex_we;
    logic [CAW-1:0]          cnt_waddr, cnt_ex_addr;
    logic [COUNT_W-1:0]      cnt_wdata, cnt_ex_data;
    logic [COUNT_W-1:0]      cnt_rd;
    logic                    stk_we;
    logic [SAW-1:0]          stk_raddr;
    logic [PAGE_W-1:0]       stk_rd;
    logic [DW-1:0]           depth_dec;

    // Datapath helpers
    logic                    page_in_range;
    logic                    alloc_in_range;
    logic                    stack_full;
    logic [COUNT_W-1:0]      cnt_dec;
    logic signed [COUNT_W+1:0] adj_sum;
    logic [COUNT_W-1:0]      adj_val;

    assign accept     = i_in_valid && o_in_ready;
    assign exec_go    = (r_state == S_EXEC) && (!r_out_valid || i_out_ready);
    assign clear_done = (r_clr_addr == CAW'(CNT_DEPTH - 1));
    assign depth_dec  = r_depth - DW'(1);
    assign stk_raddr  = depth_dec[SAW-1:0];
    assign stack_full = (r_depth == DW'(NUM_PAGES));

    assign page_in_range  = (32'(r_page) < NUM_PAGES);
    assign alloc_in_range = (32'(stk_rd) < NUM_PAGES);
    assign cnt_dec        = (cnt_rd != '0) ? (cnt_rd - COUNT_W'(1)) : '0;
    assign adj_sum        = $signed({2'b00, cnt_rd}) + $signed({{2{r_amt[AMT_W-1]}}, r_amt});
    assign adj_val        = adj_sum[COUNT_W] ? COUNT_MAX : adj_sum[COUNT_W-1:0];

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (clear_done) n_state = S_IDLE;
            S_IDLE:  if (i_in_valid) n_state = S_EXEC;
            S_EXEC:  if (exec_go)    n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        o_in_ready = 1'b0;
        unique case (r_state) inside
            S_IDLE:  o_in_ready = 1'b1;
            S_CLEAR,
            S_EXEC:  o_in_ready = 1'b0;
            default: o_in_ready = 1'b0;
        endcase
    end

    // Work out the result and the write-back for the held request
    always_comb begin
        n_status    = STAT_OK;
        n_page_out  = r_page;
        n_count     = '0;
        n_released  = 1'b0;
        n_depth     = r_depth;
        cnt_ex_we   = 1'b0;
        cnt_ex_addr = r_page[CAW-1:0];
        cnt_ex_data = '0;
        stk_we      = 1'b0;
        case (r_op)
            OP_ALLOC: begin
                if (r_depth == '0) begin
                    n_status   = STAT_EMPTY;
                    n_page_out = '0;
                end else begin
                    n_depth     = depth_dec;
                    n_page_out  = stk_rd;
                    n_count     = COUNT_W'(1);
                    cnt_ex_we   = alloc_in_range;
                    cnt_ex_addr = stk_rd[CAW-1:0];
                    cnt_ex_data = COUNT_W'(1);
                end
            end
            OP_FREE: begin
                if (!page_in_range) begin
                    n_status = STAT_RANGE;
                end else if (r_page < r_first) begin
                    n_status = STAT_RANGE;
                    n_count  = cnt_rd;
                end else begin
                    cnt_ex_we   = 1'b1;
                    cnt_ex_data = cnt_dec;
                    n_count     = cnt_dec;
                    if (cnt_dec == '0 && !stack_full) begin
                        stk_we     = 1'b1;
                        n_depth    = r_depth + DW'(1);
                        n_released = 1'b1;
                    end
                end
            end
            OP_ADJUST: begin
                if (!page_in_range) begin
                    n_status = STAT_RANGE;
                end else if (adj_sum[COUNT_W+1]) begin
                    // skip a change that would go negative
                    n_count = cnt_rd;
                end else begin
                    cnt_ex_we   = 1'b1;
                    cnt_ex_data = adj_val;
                    n_count     = adj_val;
                end
            end
            default: begin
                n_count = page_in_range ? cnt_rd : '0;
            end
        endcase
    end

    // Count store write: clearing pass or write-back
    assign cnt_we    = (r_state == S_CLEAR) || (exec_go && cnt_ex_we);
    assign cnt_waddr = (r_state == S_CLEAR) ? r_clr_addr : cnt_ex_addr;
    assign cnt_wdata = (r_state == S_CLEAR) ? '0 : cnt_ex_data;

    rpa_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (CNT_DEPTH),
        .AW    (CAW)
    ) u_count_mem (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (cnt_waddr),
        .i_wdata (cnt_wdata),
        .i_re    (accept),
        .i_raddr (i_page[CAW-1:0]),
        .o_rdata (cnt_rd)
    );

    rpa_ram #(
        .WIDTH (PAGE_W),
        .DEPTH (NUM_PAGES),
        .AW    (SAW)
    ) u_stack_mem (
        .i_clk   (i_clk),
        .i_we    (exec_go && stk_we),
        .i_waddr (r_depth[SAW-1:0]),
        .i_wdata (r_page),
        .i_re    (accept),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rd)
    );

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_depth     <= '0;
            r_first     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR && !clear_done) begin
                r_clr_addr <= r_clr_addr + CAW'(1);
            end
            if (i_cfg_we) begin
                r_first <= i_cfg_wdata;
            end
            if (exec_go) begin
                r_depth     <= n_depth;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold the accepted request
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op   <= i_operation;
            r_page <= i_page;
            r_amt  <= i_amount;
        end
    end

    // Load the result register
    always_ff @(posedge i_clk) begin
        if (exec_go) begin
            r_status   <= n_status;
            r_page_out <= n_page_out;
            r_count    <= n_count;
            r_released <= n_released;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_page_out    = r_page_out;
    assign o_count_after = r_count;
    assign o_released    = r_released;

endmodule

`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for refcounted_page_allocator: directed cases, start-up fill, random phases.
// Depends on rpa_pkg and the allocator RTL; predicts results with its own page and count model.

module tb;
    import rpa_pkg::*;

    localparam int unsigned PAGES       = NUM_PAGES_DEF;
    localparam int          CYCLE_LIMIT = 1_000_000;
    localparam int          RAND_ITEMS  = 180;
    localparam int          FILL_PAGES  = 256;
    localparam int          HELD_MAX    = 64;

    typedef struct {
        logic [OP_W-1:0]          op;
        logic [PAGE_W-1:0]        page;
        logic signed [AMT_W-1:0]  amount;
    } t_page_req;

    typedef struct {
        logic [ST_W-1:0]    status;
        logic [PAGE_W-1:0]  page;
        logic [COUNT_W-1:0] count;
        logic               released;
    } t_page_result;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_ready;
    logic [OP_W-1:0]            i_operation = OP_NOP;
    logic [PAGE_W-1:0]          i_page = '0;
    logic signed [AMT_W-1:0]    i_amount = '0;
    logic                       o_out_valid;
    logic                       i_out_ready = 1'b0;
    logic [ST_W-1:0]            o_status;
    logic [PAGE_W-1:0]          o_page_out;
    logic [COUNT_W-1:0]         o_count_after;
    logic                       o_released;
    logic                       i_cfg_we = 1'b0;
    logic [PAGE_W-1:0]          i_cfg_wdata = '0;

    // Predictor state
    logic [COUNT_W-1:0] page_refs [PAGES];
    logic [PAGE_W-1:0]  free_pages [PAGES];
    int unsigned        free_depth = 0;
    logic [PAGE_W-1:0]  usable_floor = '0;

    // Stimulus and checking bookkeeping
    t_page_req          pending_reqs[$];
    t_page_result       expected_results[$];
    logic [PAGE_W-1:0]  held_pages[$];
    t_page_req          next_req;
    t_page_result       want;
    logic               req_fire = 1'b0;
    int                 send_idle_pct = 0;
    int                 recv_stall_pct = 0;
    int                 reqs_queued = 0;
    int                 results_seen = 0;
    int                 mismatches = 0;
    int                 cycle_count = 0;

    refcounted_page_allocator #(
        .NUM_PAGES(PAGES)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_operation   (i_operation),
        .i_page        (i_page),
        .i_amount      (i_amount),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_page_out    (o_page_out),
        .o_count_after (o_count_after),
        .o_released    (o_released),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    // Apply one request to the predictor state and return the result it should give
    function automatic t_page_result apply_request(input t_page_req r);
        t_page_result res;
        int           next_count;
        res.status   = STAT_OK;
        res.page     = r.page;
        res.count    = '0;
        res.released = 1'b0;
        case (r.op)
            OP_ALLOC: begin
                if (free_depth == 0) begin
                    res.status = STAT_EMPTY;
                    res.page   = '0;
                end else begin
                    free_depth--;
                    res.page = free_pages[free_depth];
                    page_refs[res.page] = 1;
                    res.count = 1;
                    held_pages.push_back(res.page);
                    if (held_pages.size() > HELD_MAX)
                        void'(held_pages.pop_front());
                end
            end
            OP_FREE: begin
                if (r.page >= PAGES) begin
                    res.status = STAT_RANGE;
                end else if (r.page < usable_floor) begin
                    res.status = STAT_RANGE;
                    res.count  = page_refs[r.page];
                end else begin
                    if (page_refs[r.page] != 0)
                        page_refs[r.page] = page_refs[r.page] - 1;
                    res.count = page_refs[r.page];
                    if (res.count == 0 && free_depth < PAGES) begin
                        free_pages[free_depth] = r.page;
                        free_depth++;
                        res.released = 1'b1;
                    end
                end
            end
            OP_ADJUST: begin
                if (r.page >= PAGES) begin
                    res.status = STAT_RANGE;
                end else begin
                    next_count = int'(page_refs[r.page]) + int'(r.amount);
                    // skip a change that would go negative, clamp at the top
                    if (next_count >= 0) begin
                        if (next_count > int'(COUNT_MAX))
                            next_count = int'(COUNT_MAX);
                        page_refs[r.page] = COUNT_W'(next_count);
                    end
                    res.count = page_refs[r.page];
                end
            end
            default: begin
                res.count = (r.page < PAGES) ? page_refs[r.page] : '0;
            end
        endcase
        return res;
    endfunction

    task automatic compare_field(input string name, input int exp_val, input int act_val);
        if (exp_val != act_val) begin
            $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
            mismatches++;
        end
    endtask

    // Hold a new request in the small pending queue, refilling as the driver drains it
    task automatic queue_request(input logic [OP_W-1:0] op, input logic [PAGE_W-1:0] page,
                                 input logic signed [AMT_W-1:0] amount);
        t_page_req r;
        r.op     = op;
        r.page   = page;
        r.amount = amount;
        while (pending_reqs.size() >= 4)
            @(posedge i_clk);
        pending_reqs.push_back(r);
        reqs_queued++;
    endtask

    task automatic wait_drained();
        while (results_seen < reqs_queued)
            @(posedge i_clk);
    endtask

    task automatic write_floor(input logic [PAGE_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        usable_floor = value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    function automatic logic [PAGE_W-1:0] pick_page();
        int sel;
        sel = $urandom_range(99);
        if (sel < 45 && held_pages.size() != 0)
            return held_pages[$urandom_range(held_pages.size() - 1)];
        else if (sel < 70)
            return PAGE_W'($urandom_range(15));
        else if (sel < 85)
            return PAGE_W'(int'(usable_floor) + $urandom_range(4) - 2);
        return PAGE_W'($urandom);
    endfunction

    task automatic random_phase(input logic [PAGE_W-1:0] floor_value, input int idle_pct,
                                input int stall_pct);
        int                      sel;
        logic signed [AMT_W-1:0] amt;
        write_floor(floor_value);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int n = 0; n < RAND_ITEMS; n++) begin
            sel = $urandom_range(99);
            if ($urandom_range(1) == 0)
                amt = AMT_W'($urandom_range(6) - 3);
            else
                amt = AMT_W'($urandom_range(255));
            if (sel < 30)
                queue_request(OP_ALLOC, PAGE_W'($urandom), amt);
            else if (sel < 60)
                queue_request(OP_FREE, pick_page(), amt);
            else if (sel < 90)
                queue_request(OP_ADJUST, pick_page(), amt);
            else
                queue_request(OP_NOP, PAGE_W'($urandom), amt);
        end
        wait_drained();
    endtask

    // Drive requests and result-side backpressure on the falling edge
    always @(negedge i_clk) begin
        if (!i_in_valid || req_fire) begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                next_req    = pending_reqs.pop_front();
                i_in_valid  <= 1'b1;
                i_operation <= next_req.op;
                i_page      <= next_req.page;
                i_amount    <= next_req.amount;
            end else begin
                i_in_valid  <= 1'b0;
            end
        end
        i_out_ready <= i_rst_n && ($urandom_range(99) >= recv_stall_pct);
    end

    // Predict on each accepted request, check each accepted result
    always @(posedge i_clk) begin
        req_fire <= i_in_valid && o_in_ready;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready)
                expected_results.push_back(apply_request('{i_operation, i_page, i_amount}));
            if (o_out_valid && i_out_ready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    $error("result with none expected: page_out %0d", o_page_out);
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    compare_field("status", want.status, o_status);
                    compare_field("page_out", want.page, o_page_out);
                    compare_field("count_after", want.count, o_count_after);
                    compare_field("released", want.released, o_released);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    initial begin
        for (int p = 0; p < PAGES; p++)
            page_refs[p] = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty stack, saturation, skipped negative adjust, repeated free
        queue_request(OP_ALLOC, 15'h1234, 8'sd0);
        queue_request(OP_NOP, 15'h7FFF, 8'sd0);
        queue_request(OP_ADJUST, 15'd5, 8'sd127);
        queue_request(OP_ADJUST, 15'd5, 8'sd127);
        queue_request(OP_ADJUST, 15'd5, 8'sd127);
        queue_request(OP_ADJUST, 15'd5, -8'sd128);
        queue_request(OP_ADJUST, 15'd5, -8'sd128);
        queue_request(OP_FREE, 15'd5, 8'sd0);
        queue_request(OP_FREE, 15'h7FFF, 8'sd0);
        queue_request(OP_FREE, 15'h7FFF, 8'sd0);
        queue_request(OP_ALLOC, 15'd0, 8'sd0);
        queue_request(OP_ALLOC, 15'd0, 8'sd0);
        queue_request(OP_ALLOC, 15'd0, 8'sd0);
        queue_request(OP_FREE, 15'd0, 8'sd0);
        queue_request(OP_ADJUST, 15'd0, -8'sd1);
        queue_request(OP_NOP, 15'd5, 8'sd0);
        wait_drained();

        // Directed: highest floor, frees below it are refused, adjust ignores it
        write_floor(15'h7FFF);
        queue_request(OP_FREE, 15'h7FFE, 8'sd0);
        queue_request(OP_FREE, 15'd5, 8'sd0);
        queue_request(OP_FREE, 15'h7FFF, 8'sd0);
        queue_request(OP_ADJUST, 15'd3, 8'sd1);
        queue_request(OP_ALLOC, 15'd0, 8'sd0);
        queue_request(OP_NOP, 15'h2AAA, -8'sd1);
        wait_drained();

        // Start-up: free a block of 256 pages onto the stack, then push page 0 again and again
        write_floor('0);
        for (int p = 0; p < FILL_PAGES; p++)
            queue_request(OP_FREE, PAGE_W'(p), 8'sd0);
        for (int k = 0; k < 8; k++)
            queue_request(OP_FREE, 15'd0, 8'sd0);
        wait_drained();

        random_phase('0, 0, 0);
        random_phase(15'd12, 77, 0);
        random_phase(PAGE_W'($urandom_range(32766, 1)), 0, 77);
        random_phase(15'h7FFF, 28, 28);

        // Let any stray result surface before the verdict
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/rpa_pkg.sv
hw/rtl/rpa_ram.sv
hw/rtl/refcounted_page_allocator.sv
test/tb.sv
